@@ rtl/mbq_pkg.sv @@
// Shared types and constants for the multichannel biquad filter.
// Holds the transfer payload structs, operation and register codes, and
// the fixed sample, coefficient and accumulator formats. No dependencies.
`default_nettype none
package mbq_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int COEF_W      = 32;
  localparam int COEF_FRAC   = 28;
  localparam int PROD_W      = COEF_W + SAMPLE_W;
  localparam int ACC_W       = 64;
  localparam int CHAN_W      = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int DEF_MAX_CHANNELS = 8;

  typedef enum logic {
    OP_FILTER = 1'b0,
    OP_CLEAR  = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } reg_idx_t;

  typedef struct packed {
    op_t                        operation;
    logic [CHAN_W-1:0]          channel;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       end_of_block;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic [CHAN_W-1:0]          channel_out;
    logic                       block_end_out;
  } out_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x1;
    logic signed [SAMPLE_W-1:0] x2;
    logic signed [SAMPLE_W-1:0] y1;
    logic signed [SAMPLE_W-1:0] y2;
  } hist_t;

  typedef struct packed {
    logic acc_init;
    logic mul_en;
    logic mul_sub;
    logic acc_en;
  } mac_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/mbq_hist.sv @@
// Per-channel filter history: two input and two output samples per channel.
// Uses mbq_pkg for the sample width and the history struct.
`default_nettype none
module mbq_hist import mbq_pkg::*; #(
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       clear,
  input  wire logic                       we,
  input  wire logic [IDX_W-1:0]           idx,
  input  wire logic signed [SAMPLE_W-1:0] x_new,
  input  wire logic signed [SAMPLE_W-1:0] y_new,
  output hist_t                           rd
);

  hist_t hist_r [MAX_CHANNELS];

  assign rd = hist_r[idx];

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        hist_r[i] <= '0;
      end
    end else if (we) begin
      hist_r[idx].x2 <= hist_r[idx].x1;
      hist_r[idx].x1 <= x_new;
      hist_r[idx].y2 <= hist_r[idx].y1;
      hist_r[idx].y1 <= y_new;
    end
  end

endmodule
`default_nettype wire

@@ rtl/mbq_mac.sv @@
// Shared multiply-accumulate unit with round-half-up and saturation.
// One product per cycle is registered while mul_en is set, then added or subtracted next cycle.
// Uses mbq_pkg for formats and the control struct.
`default_nettype none
module mbq_mac import mbq_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire mac_ctrl_t                  ctrl,
  input  wire logic signed [COEF_W-1:0]   coef,
  input  wire logic signed [SAMPLE_W-1:0] operand,
  output logic signed [SAMPLE_W-1:0]      y_sat
);

  localparam logic [ACC_W-1:0] ROUND_C = ACC_W'(1) << (COEF_FRAC - 1);
  localparam logic signed [ACC_W-1:0] Y_MAX = (ACC_W'(1) << (SAMPLE_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] Y_MIN = -Y_MAX - ACC_W'(1);

  logic signed [PROD_W-1:0] prod_r;
  logic                     sub_r;
  logic [ACC_W-1:0]         acc_r;
  logic signed [ACC_W-1:0]  shifted;
  logic [ACC_W-1:0]         prod_ext;

  assign prod_ext = ACC_W'(prod_r);
  assign shifted  = $signed(acc_r) >>> COEF_FRAC;

  always_comb begin
    if (shifted > Y_MAX) begin
      y_sat = Y_MAX[SAMPLE_W-1:0];
    end else if (shifted < Y_MIN) begin
      y_sat = Y_MIN[SAMPLE_W-1:0];
    end else begin
      y_sat = shifted[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= PROD_W'(coef) * PROD_W'(operand);
      sub_r  <= ctrl.mul_sub;
    end
    if (!rst_n || ctrl.acc_init) begin
      acc_r <= ROUND_C;
    end else if (ctrl.acc_en) begin
      acc_r <= sub_r ? acc_r - prod_ext : acc_r + prod_ext;
    end
  end

endmodule
`default_nettype wire

@@ rtl/multichannel_biquad_filter_core.sv @@
// Multichannel direct-form-I biquad filter, top level with the sequencer.
// Depends on mbq_pkg, mbq_hist and mbq_mac.
//
//   Port group  Direction  Handshake        Payload
//   in_         input      valid / stall    in_item_t
//   out_        output     valid / stall    out_item_t
//   cfg_        input      write enable     index and 32-bit coefficient
//
// A filter item is accepted, runs on the shared multiplier and accumulator
// (five products plus the last add), and a final step rounds, saturates and
// updates the channel history; in_ stalls until that step is done. Clear
// items and absent-channel items start no sequence. Reset is synchronous and
// zeroes the coefficients and all histories. A waiting result does not block
// the next transfer in; only the final step waits on a stalled output.
`default_nettype none
module multichannel_biquad_filter_core import mbq_pkg::*; #(
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire in_item_t               in_item,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output out_item_t                   out_item,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [COEF_W-1:0]      cfg_wdata
);

  localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    STEP_B0,
    STEP_B1,
    STEP_B2,
    STEP_A1,
    STEP_A2,
    STEP_DRAIN
  } step_t;

  state_t                     state_r;
  step_t                      step_r;
  logic signed [COEF_W-1:0]   coef_b0_r, coef_b1_r, coef_b2_r, coef_a1_r, coef_a2_r;
  logic signed [SAMPLE_W-1:0] x_r;
  logic [CHAN_W-1:0]          ch_r;
  logic                       eob_r;
  logic                       out_valid_r;
  out_item_t                  out_item_r;

  logic                       in_fire;
  logic                       chan_ok;
  logic                       out_free;
  logic                       hist_we;
  logic                       hist_clear;
  hist_t                      hist_rd;
  mac_ctrl_t                  mac_ctrl;
  logic signed [COEF_W-1:0]   mul_coef;
  logic signed [SAMPLE_W-1:0] mul_op;
  logic signed [SAMPLE_W-1:0] y_sat;

  assign in_stall   = (state_r != ST_IDLE);
  assign in_fire    = in_valid && !in_stall;
  assign chan_ok    = (int'(in_item.channel) < MAX_CHANNELS);
  assign out_free   = !out_valid_r || !out_stall;
  assign hist_we    = (state_r == ST_FIN) && out_free;
  assign hist_clear = in_fire && (in_item.operation == OP_CLEAR);
  assign out_valid  = out_valid_r;
  assign out_item   = out_item_r;

  always_comb begin
    case (step_r)
      STEP_B0: begin
        mul_coef = coef_b0_r;
        mul_op   = x_r;
      end
      STEP_B1: begin
        mul_coef = coef_b1_r;
        mul_op   = hist_rd.x1;
      end
      STEP_B2: begin
        mul_coef = coef_b2_r;
        mul_op   = hist_rd.x2;
      end
      STEP_A1: begin
        mul_coef = coef_a1_r;
        mul_op   = hist_rd.y1;
      end
      STEP_A2: begin
        mul_coef = coef_a2_r;
        mul_op   = hist_rd.y2;
      end
      default: begin
        mul_coef = '0;
        mul_op   = '0;
      end
    endcase
  end

  always_comb begin
    mac_ctrl.acc_init = in_fire;
    mac_ctrl.mul_en   = (state_r == ST_MAC) && (step_r != STEP_DRAIN);
    mac_ctrl.mul_sub  = (step_r == STEP_A1) || (step_r == STEP_A2);
    mac_ctrl.acc_en   = (state_r == ST_MAC) && (step_r != STEP_B0);
  end

  mbq_hist #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_hist (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (hist_clear),
    .we    (hist_we),
    .idx   (IDX_W'(ch_r)),
    .x_new (x_r),
    .y_new (y_sat),
    .rd    (hist_rd)
  );

  mbq_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (mac_ctrl),
    .coef    (mul_coef),
    .operand (mul_op),
    .y_sat   (y_sat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_b0_r <= '0;
      coef_b1_r <= '0;
      coef_b2_r <= '0;
      coef_a1_r <= '0;
      coef_a2_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_B0:  coef_b0_r <= cfg_wdata;
        REG_B1:  coef_b1_r <= cfg_wdata;
        REG_B2:  coef_b2_r <= cfg_wdata;
        REG_A1:  coef_a1_r <= cfg_wdata;
        REG_A2:  coef_a2_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= STEP_B0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && !hist_we) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          step_r <= STEP_B0;
          if (in_fire && (in_item.operation == OP_FILTER) && chan_ok) begin
            state_r <= ST_MAC;
            x_r     <= in_item.sample_in;
            ch_r    <= in_item.channel;
            eob_r   <= in_item.end_of_block;
          end
        end
        ST_MAC: begin
          if (step_r == STEP_DRAIN) begin
            state_r <= ST_FIN;
          end else begin
            step_r <= step_t'(step_r + 3'd1);
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state_r                  <= ST_IDLE;
            out_valid_r              <= 1'b1;
            out_item_r.sample_out    <= y_sat;
            out_item_r.channel_out   <= ch_r;
            out_item_r.block_end_out <= eob_r;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result appeared without a finishing step");

  a_hist_write_safe: assert property (@(posedge clk) disable iff (!rst_n)
    hist_we |=> out_valid_r)
    else $error("history updated without a result being loaded");

  a_acc_ctrl_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(mac_ctrl.acc_init && (mac_ctrl.acc_en || mac_ctrl.mul_en)))
    else $error("accumulator started while the unit was busy");

  a_filter_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_item.operation == OP_FILTER) && chan_ok)
      |=> (state_r == ST_MAC) && (step_r == STEP_B0))
    else $error("accepted filter item did not start the sequence");
`endif

endmodule
`default_nettype wire

@@ dv/mbq_biquad_checker.sv @@
// Checker for the multichannel biquad filter: predicts each filtered sample
// from the observed coefficient writes and input transfers, then compares results.
// Depends on mbq_pkg.
`timescale 1ns / 1ps
module mbq_biquad_checker import mbq_pkg::*; #(
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_stall,
  input  in_item_t                  in_item,
  input  wire logic                 out_valid,
  input  wire logic                 out_stall,
  input  out_item_t                 out_item,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COEF_W-1:0]    cfg_wdata,
  output int                        fail_count,
  output int                        outstanding
);

  localparam longint Y_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint Y_MIN = -Y_MAX - 1;
  localparam longint ROUND_HALF = longint'(1) <<< (COEF_FRAC - 1);

  logic signed [COEF_W-1:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  logic signed [SAMPLE_W-1:0] x1_hist [MAX_CHANNELS];
  logic signed [SAMPLE_W-1:0] x2_hist [MAX_CHANNELS];
  logic signed [SAMPLE_W-1:0] y1_hist [MAX_CHANNELS];
  logic signed [SAMPLE_W-1:0] y2_hist [MAX_CHANNELS];
  out_item_t pending_results [$];

  function automatic void clear_histories();
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      x1_hist[i] = '0;
      x2_hist[i] = '0;
      y1_hist[i] = '0;
      y2_hist[i] = '0;
    end
  endfunction

  function automatic out_item_t filter_sample(in_item_t it);
    longint acc;
    longint rounded;
    logic signed [SAMPLE_W-1:0] y;
    out_item_t res;
    acc = longint'(coef_b0) * longint'(it.sample_in)
        + longint'(coef_b1) * longint'(x1_hist[it.channel])
        + longint'(coef_b2) * longint'(x2_hist[it.channel])
        - longint'(coef_a1) * longint'(y1_hist[it.channel])
        - longint'(coef_a2) * longint'(y2_hist[it.channel]);
    rounded = (acc + ROUND_HALF) >>> COEF_FRAC;
    if (rounded > Y_MAX) begin
      y = {1'b0, {(SAMPLE_W - 1){1'b1}}};
    end else if (rounded < Y_MIN) begin
      y = {1'b1, {(SAMPLE_W - 1){1'b0}}};
    end else begin
      y = rounded[SAMPLE_W-1:0];
    end
    x2_hist[it.channel] = x1_hist[it.channel];
    x1_hist[it.channel] = it.sample_in;
    y2_hist[it.channel] = y1_hist[it.channel];
    y1_hist[it.channel] = y;
    res.sample_out = y;
    res.channel_out = it.channel;
    res.block_end_out = it.end_of_block;
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      coef_b0 = '0;
      coef_b1 = '0;
      coef_b2 = '0;
      coef_a1 = '0;
      coef_a2 = '0;
      clear_histories();
      pending_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_B0: coef_b0 = cfg_wdata;
          REG_B1: coef_b1 = cfg_wdata;
          REG_B2: coef_b2 = cfg_wdata;
          REG_A1: coef_a1 = cfg_wdata;
          REG_A2: coef_a2 = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("Result with no expected entry: sample_out %0d, channel_out %0d",
                 out_item.sample_out, out_item.channel_out);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_item.sample_out !== want.sample_out) begin
            $error("sample_out mismatch: expected %0d, actual %0d",
                   want.sample_out, out_item.sample_out);
            fail_count++;
          end
          if (out_item.channel_out !== want.channel_out) begin
            $error("channel_out mismatch: expected %0d, actual %0d",
                   want.channel_out, out_item.channel_out);
            fail_count++;
          end
          if (out_item.block_end_out !== want.block_end_out) begin
            $error("block_end_out mismatch: expected %0d, actual %0d",
                   want.block_end_out, out_item.block_end_out);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_item.operation == OP_CLEAR) begin
          clear_histories();
        end else if (in_item.channel < MAX_CHANNELS) begin
          pending_results.push_back(filter_sample(in_item));
        end
      end
    end
    outstanding = pending_results.size();
  end

endmodule

@@ dv/tb_multichannel_biquad_filter_core.sv @@
// Top-level testbench for the multichannel biquad filter: drives coefficient
// writes and sample transfers and reports the verdict. Depends on mbq_pkg,
// the filter core and mbq_biquad_checker.
`timescale 1ns / 1ps
module tb_multichannel_biquad_filter_core;
  import mbq_pkg::*;

  localparam int NUM_REGS = 5;
  localparam int BLOCK_ITEMS = 165;
  localparam int DRAIN_CYCLES = 16;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int COEF_RANGE = 201326592;

  localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W - 1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W - 1){1'b0}}};
  localparam logic signed [COEF_W-1:0] C_MAX = {1'b0, {(COEF_W - 1){1'b1}}};
  localparam logic signed [COEF_W-1:0] C_MIN = {1'b1, {(COEF_W - 1){1'b0}}};
  localparam logic signed [COEF_W-1:0] C_ONE = 32'sd268435456;
  localparam logic signed [COEF_W-1:0] C_HALF = 32'sd134217728;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_item;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0] cfg_wdata;
  int fail_count;
  int outstanding;
  int send_idle_pct;
  int recv_idle_pct;
  int quiet_cycles = 0;

  multichannel_biquad_filter_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  mbq_biquad_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall = ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL multichannel_biquad_filter_core");
      $finish;
    end
  end

  function automatic in_item_t make_item(op_t op, int ch, logic signed [SAMPLE_W-1:0] x,
                                         logic eob);
    in_item_t it;
    it.operation = op;
    it.channel = ch[CHAN_W-1:0];
    it.sample_in = x;
    it.end_of_block = eob;
    return it;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    logic [31:0] bits;
    int pick;
    bits = $urandom;
    pick = $urandom_range(0, 9);
    it.operation = ($urandom_range(0, 99) < 3) ? OP_CLEAR : OP_FILTER;
    it.channel = bits[CHAN_W-1:0];
    it.end_of_block = bits[CHAN_W];
    bits = $urandom;
    case (pick)
      0: it.sample_in = S_MAX;
      1: it.sample_in = S_MIN;
      2, 3: it.sample_in = {{(SAMPLE_W - 9){bits[8]}}, bits[8:0]};
      default: it.sample_in = bits[SAMPLE_W-1:0];
    endcase
    return it;
  endfunction

  function automatic logic signed [COEF_W-1:0] rand_coef(bit full_range);
    logic [31:0] bits;
    int v;
    bits = $urandom;
    v = $urandom_range(0, 2 * COEF_RANGE);
    v = v - COEF_RANGE;
    return full_range ? bits[COEF_W-1:0] : COEF_W'(v);
  endfunction

  task automatic send_item(in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_item = it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_filter();
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic load_coefs(logic signed [COEF_W-1:0] b0, b1, b2, a1, a2);
    logic [31:0] bits;
    logic signed [COEF_W-1:0] vals [NUM_REGS];
    vals = '{b0, b1, b2, a1, a2};
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we = 1'b1;
      cfg_index = CFG_IDX_W'(i);
      cfg_wdata = vals[i];
      @(negedge clk);
    end
    bits = $urandom;
    cfg_index = CFG_IDX_W'($urandom_range(NUM_REGS, (1 << CFG_IDX_W) - 1));
    cfg_wdata = bits[COEF_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin : stimulus
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    send_idle_pct = 25;
    recv_idle_pct = 74;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Coefficients are zero after reset, so every result is zero.
    send_item(make_item(OP_FILTER, 0, S_MAX, 1'b1));
    send_item(make_item(OP_FILTER, 7, S_MIN, 1'b0));
    drain_filter();

    load_coefs(C_ONE, '0, '0, '0, '0);
    send_item(make_item(OP_FILTER, 0, S_MAX, 1'b0));
    send_item(make_item(OP_FILTER, 0, S_MIN, 1'b1));
    send_item(make_item(OP_FILTER, 3, '0, 1'b0));
    send_item(make_item(OP_FILTER, 3, -24'sd1, 1'b1));
    send_item(make_item(OP_FILTER, 7, 24'sd1, 1'b1));
    send_item(make_item(OP_CLEAR, 5, S_MIN, 1'b1));
    drain_filter();

    // Half-weight taps put some of the accumulator values exactly on rounding boundaries.
    load_coefs(C_HALF, C_ONE, -C_HALF, '0, '0);
    send_item(make_item(OP_FILTER, 1, 24'sd1, 1'b0));
    send_item(make_item(OP_FILTER, 1, -24'sd1, 1'b0));
    send_item(make_item(OP_FILTER, 1, 24'sd3, 1'b1));
    send_item(make_item(OP_FILTER, 1, -24'sd3, 1'b0));
    drain_filter();

    load_coefs(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX);
    send_item(make_item(OP_FILTER, 2, S_MAX, 1'b0));
    send_item(make_item(OP_FILTER, 2, S_MAX, 1'b0));
    send_item(make_item(OP_FILTER, 2, S_MIN, 1'b1));
    send_item(make_item(OP_FILTER, 2, S_MIN, 1'b0));
    send_item(make_item(OP_FILTER, 5, S_MIN, 1'b1));
    send_item(make_item(OP_FILTER, 5, -24'sd1, 1'b0));
    send_item(make_item(OP_CLEAR, 0, '0, 1'b0));
    send_item(make_item(OP_FILTER, 2, S_MAX, 1'b1));
    drain_filter();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 25;
          recv_idle_pct = 74;
        end
        1: begin
          send_idle_pct = 74;
          recv_idle_pct = 25;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int blk = 0; blk < 4; blk++) begin
        drain_filter();
        case (blk)
          0: load_coefs(32'sd18119393, 32'sd36238787, 32'sd18119393,
                        -32'sd306821726, 32'sd110810157);
          2: load_coefs(rand_coef(1'b1), rand_coef(1'b1), rand_coef(1'b1),
                        rand_coef(1'b1), rand_coef(1'b1));
          default: load_coefs(rand_coef(1'b0), rand_coef(1'b0), rand_coef(1'b0),
                              rand_coef(1'b0), rand_coef(1'b0));
        endcase
        for (int n = 0; n < BLOCK_ITEMS; n++) begin
          send_item(rand_item());
        end
      end
    end

    drain_filter();
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS multichannel_biquad_filter_core");
    end else begin
      $display("FAIL multichannel_biquad_filter_core");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/mbq_pkg.sv
rtl/mbq_hist.sv
rtl/mbq_mac.sv
rtl/multichannel_biquad_filter_core.sv
dv/mbq_biquad_checker.sv
dv/tb_multichannel_biquad_filter_core.sv
